[design/shb_pkg.sv]
// shared types and constants of the string hash bank
`default_nettype none
package shb_pkg;

   localparam int unsigned HASH_W       = 32;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned INDEX_W      = 4;
   localparam int unsigned COUNT_W      = 11;
   localparam int unsigned PART_W       = 10;

   // remainder unit: bits of the dividend consumed per cycle
   localparam int unsigned BITS_PER_STEP = 4;
   localparam int unsigned DIV_STEPS     = HASH_W / BITS_PER_STEP;
   localparam int unsigned STEP_CNT_W    = $clog2(DIV_STEPS);

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 11'd1024;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

   localparam logic [HASH_W-1:0] RS_MULT_INIT = 32'd63689;
   localparam logic [HASH_W-1:0] RS_MULT_STEP = 32'd378551;
   localparam logic [HASH_W-1:0] JS_INIT      = 32'd1315423911;
   localparam logic [HASH_W-1:0] DJB_INIT     = 32'd5381;
   localparam logic [HASH_W-1:0] FNV_MULT     = 32'h811C9DC5;
   localparam logic [HASH_W-1:0] AP_INIT      = 32'hAAAAAAAA;
   localparam logic [HASH_W-1:0] TOP_NIBBLE   = 32'hF0000000;

   // hash selection codes
   localparam logic [INDEX_W-1:0] IDX_RS   = 4'd0;
   localparam logic [INDEX_W-1:0] IDX_JS   = 4'd1;
   localparam logic [INDEX_W-1:0] IDX_PJW  = 4'd2;
   localparam logic [INDEX_W-1:0] IDX_ELF  = 4'd3;
   localparam logic [INDEX_W-1:0] IDX_BKDR = 4'd4;
   localparam logic [INDEX_W-1:0] IDX_SDBM = 4'd5;
   localparam logic [INDEX_W-1:0] IDX_DJB  = 4'd6;
   localparam logic [INDEX_W-1:0] IDX_DEK  = 4'd7;
   localparam logic [INDEX_W-1:0] IDX_BP   = 4'd8;
   localparam logic [INDEX_W-1:0] IDX_FNV  = 4'd9;
   localparam logic [INDEX_W-1:0] IDX_AP   = 4'd10;

   typedef struct packed {
      logic [HASH_W-1:0] rs;
      logic [HASH_W-1:0] rs_mult;
      logic [HASH_W-1:0] js;
      logic [HASH_W-1:0] pjw;
      logic [HASH_W-1:0] elf;
      logic [HASH_W-1:0] bkdr;
      logic [HASH_W-1:0] sdbm;
      logic [HASH_W-1:0] djb;
      logic [HASH_W-1:0] dek;
      logic [HASH_W-1:0] bp;
      logic [HASH_W-1:0] fnv;
      logic [HASH_W-1:0] ap;
      logic              parity;
   } hashes_type;

   localparam hashes_type HASH_INIT = '{
      rs:      '0,
      rs_mult: RS_MULT_INIT,
      js:      JS_INIT,
      pjw:     '0,
      elf:     '0,
      bkdr:    '0,
      sdbm:    '0,
      djb:     DJB_INIT,
      dek:     '0,
      bp:      '0,
      fnv:     '0,
      ap:      AP_INIT,
      parity:  1'b0
   };

   // controller to datapath
   typedef struct packed {
      logic fold;   // item accepted: update the hashes
      logic load;   // start the remainder unit
      logic step;   // one remainder step
      logic emit;   // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic term_item;   // presented item ends a key
   } status_type;

endpackage
`default_nettype wire

[design/shb_if.sv]
// channel interfaces of the string hash bank
`default_nettype none
interface shb_req_if;
   logic                           valid;
   logic                           ready;
   logic [shb_pkg::BYTE_W-1:0]     data_byte;
   logic                           first_byte;
   logic                           last_byte;
   logic                           is_empty;
   logic [shb_pkg::HASH_W-1:0]     key_length;
   logic [shb_pkg::INDEX_W-1:0]    hash_index;

   modport source (output valid, data_byte, first_byte, last_byte, is_empty, key_length,
                   hash_index, input ready);
   modport sink (input valid, data_byte, first_byte, last_byte, is_empty, key_length,
                 hash_index, output ready);
endinterface

interface shb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [shb_pkg::HASH_W-1:0]   hash_value;
   logic                         index_error;
   logic [shb_pkg::PART_W-1:0]   partition;

   modport source (output valid, hash_value, index_error, partition, input ready);
   modport sink (input valid, hash_value, index_error, partition, output ready);
endinterface

interface shb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [shb_pkg::COUNT_W-1:0]   instance_count;

   modport source (output valid, instance_count, input ready);
   modport sink (input valid, instance_count, output ready);
endinterface
`default_nettype wire

[design/shb_ctrl.sv]
// controller of the string hash bank: accept, remainder steps, result hand-off
`default_nettype none
module shb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire shb_pkg::status_type  status,
   output shb_pkg::cmd_type          cmd
);

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_LOAD   = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   localparam logic [shb_pkg::STEP_CNT_W-1:0] LAST_STEP =
      shb_pkg::STEP_CNT_W'(shb_pkg::DIV_STEPS - 1);

   logic [1:0]                        state_ff, state_in;
   logic [shb_pkg::STEP_CNT_W-1:0]    step_cnt_ff, step_cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              fire;
   logic                              out_free;

   assign req_ready = (state_ff == ST_ACCEPT);
   assign fire      = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      cmd         = '0;
      cmd.fold    = fire;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (fire && status.term_item) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load    = 1'b1;
            step_cnt_in = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.step    = 1'b1;
            step_cnt_in = step_cnt_ff + 1'b1;
            if (step_cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_comb begin
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[design/shb_datapath.sv]
// datapath of the string hash bank: hash registers, remainder unit, result register
`default_nettype none
module shb_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire shb_pkg::cmd_type                cmd,
   output shb_pkg::status_type                  status,
   input  wire logic [shb_pkg::BYTE_W-1:0]      req_data_byte,
   input  wire logic                            req_first_byte,
   input  wire logic                            req_last_byte,
   input  wire logic                            req_is_empty,
   input  wire logic [shb_pkg::HASH_W-1:0]      req_key_length,
   input  wire logic [shb_pkg::INDEX_W-1:0]     req_hash_index,
   input  wire logic                            csr_write,
   input  wire logic [shb_pkg::COUNT_W-1:0]     csr_instance_count,
   output logic [shb_pkg::HASH_W-1:0]           rsp_hash_value,
   output logic                                 rsp_index_error,
   output logic [shb_pkg::PART_W-1:0]           rsp_partition
);

   localparam int unsigned HW = shb_pkg::HASH_W;

   shb_pkg::hashes_type            hashes_ff, hashes_in;
   shb_pkg::hashes_type            base;
   shb_pkg::hashes_type            folded;
   logic [shb_pkg::INDEX_W-1:0]    sel_ff, sel_in;
   logic [shb_pkg::COUNT_W-1:0]    count_ff;

   logic                           start;
   logic [HW-1:0]                  c;
   logic [HW-1:0]                  rs_prod;
   logic [HW-1:0]                  mult_prod;
   logic [HW-1:0]                  fnv_prod;
   logic [HW-1:0]                  ap_prod;
   logic [HW-1:0]                  pjw_h, pjw_t;
   logic [HW-1:0]                  elf_h, elf_t;

   // remainder unit
   logic [HW-1:0]                  dividend_ff, dividend_in;
   logic [shb_pkg::PART_W-1:0]     rem_ff, rem_in;
   logic [shb_pkg::COUNT_W-1:0]    divisor_ff, divisor_in;
   logic [shb_pkg::COUNT_W-1:0]    trial;
   logic [HW-1:0]                  shift_word;

   logic [HW-1:0]                  sel_hash;

   // result register
   logic [HW-1:0]                  hash_value_ff;
   logic                           index_error_ff;
   logic [shb_pkg::PART_W-1:0]     partition_ff;

   assign status.term_item = req_last_byte | req_is_empty;

   assign start = req_is_empty | req_first_byte;
   assign c     = {{(HW - shb_pkg::BYTE_W){req_data_byte[shb_pkg::BYTE_W-1]}}, req_data_byte};

   always_comb begin
      base = hashes_ff;
      if (start) begin
         base     = shb_pkg::HASH_INIT;
         base.dek = req_key_length;
         base.bp  = req_key_length;
      end
   end

   assign rs_prod   = base.rs * base.rs_mult;
   assign mult_prod = base.rs_mult * shb_pkg::RS_MULT_STEP;
   assign fnv_prod  = base.fnv * shb_pkg::FNV_MULT;
   assign ap_prod   = c * (base.ap >> 3);

   always_comb begin
      pjw_h = (base.pjw << 4) + c;
      pjw_t = pjw_h & shb_pkg::TOP_NIBBLE;
      elf_h = (base.elf << 4) + c;
      elf_t = elf_h & shb_pkg::TOP_NIBBLE;

      folded         = base;
      folded.rs      = rs_prod + c;
      folded.rs_mult = mult_prod;
      folded.js      = base.js ^ ((base.js << 5) + c + (base.js >> 2));
      // top nibble folded back into bits 4..7 and cleared
      folded.pjw     = (pjw_h ^ (pjw_t >> 24)) & ~shb_pkg::TOP_NIBBLE;
      folded.elf     = (elf_h ^ (elf_t >> 24)) & ~elf_t;
      folded.bkdr    = (base.bkdr << 7) + (base.bkdr << 1) + base.bkdr + c;
      folded.sdbm    = c + (base.sdbm << 6) + (base.sdbm << 16) - base.sdbm;
      folded.djb     = (base.djb << 5) + base.djb + c;
      folded.dek     = ((base.dek << 5) ^ (base.dek >> 27)) ^ c;
      folded.bp      = (base.bp << 7) ^ c;
      folded.fnv     = fnv_prod ^ c;
      if (!base.parity) begin
         folded.ap = base.ap ^ ((base.ap << 7) ^ ap_prod);
      end else begin
         folded.ap = base.ap ^ ~((base.ap << 11) + (c ^ (base.ap >> 5)));
      end
      folded.parity  = ~base.parity;

      hashes_in = req_is_empty ? base : folded;
      sel_in    = start ? req_hash_index : sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hashes_ff <= shb_pkg::HASH_INIT;
         sel_ff    <= '0;
         count_ff  <= shb_pkg::COUNT_RESET;
      end else begin
         if (cmd.fold) begin
            hashes_ff <= hashes_in;
            sel_ff    <= sel_in;
         end
         if (csr_write) begin
            count_ff <= csr_instance_count;
         end
      end
   end

   // restoring remainder, several dividend bits per cycle, msb first
   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      trial       = '0;
      shift_word  = dividend_ff;
      if (cmd.load) begin
         dividend_in = hashes_ff.bkdr;
         rem_in      = '0;
         priority if (count_ff == '0) begin
            divisor_in = shb_pkg::COUNT_RESET;
         end else if (count_ff > shb_pkg::COUNT_MAX) begin
            divisor_in = shb_pkg::COUNT_MAX;
         end else begin
            divisor_in = count_ff;
         end
      end else if (cmd.step) begin
         for (int i = 0; i < shb_pkg::BITS_PER_STEP; i++) begin
            trial = {rem_in, shift_word[HW-1]};
            shift_word = shift_word << 1;
            if (trial >= divisor_ff) begin
               trial = trial - divisor_ff;
            end
            rem_in = trial[shb_pkg::PART_W-1:0];
         end
         dividend_in = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
   end

   always_comb begin
      unique case (sel_ff)
         shb_pkg::IDX_RS:   sel_hash = hashes_ff.rs;
         shb_pkg::IDX_JS:   sel_hash = hashes_ff.js;
         shb_pkg::IDX_PJW:  sel_hash = hashes_ff.pjw;
         shb_pkg::IDX_ELF:  sel_hash = hashes_ff.elf;
         shb_pkg::IDX_BKDR: sel_hash = hashes_ff.bkdr;
         shb_pkg::IDX_SDBM: sel_hash = hashes_ff.sdbm;
         shb_pkg::IDX_DJB:  sel_hash = hashes_ff.djb;
         shb_pkg::IDX_DEK:  sel_hash = hashes_ff.dek;
         shb_pkg::IDX_BP:   sel_hash = hashes_ff.bp;
         shb_pkg::IDX_FNV:  sel_hash = hashes_ff.fnv;
         shb_pkg::IDX_AP:   sel_hash = hashes_ff.ap;
         default:           sel_hash = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         hash_value_ff  <= sel_hash;
         index_error_ff <= (sel_ff > shb_pkg::IDX_AP);
         partition_ff   <= rem_ff;
      end
   end

   assign rsp_hash_value  = hash_value_ff;
   assign rsp_index_error = index_error_ff;
   assign rsp_partition   = partition_ff;

endmodule
`default_nettype wire

[design/string_hash_bank.sv]
// top level of the string hash bank
// Key bytes arrive one per item; an item that does not end a key is taken with req ready
// kept high, and all eleven hashes are updated as it is accepted. An item that ends a key
// (last byte or empty key) holds req ready low while the remainder unit is loaded, the
// BKDR-131 hash is reduced modulo the clamped instance_count at 4 dividend bits per cycle,
// and the result register is written once the previous result is taken. The result waits
// there; instance_count must be written through csr while no key is open (not enforced).
`default_nettype none
module string_hash_bank (
   input  wire logic  clock,
   input  wire logic  reset,
   shb_req_if.sink    req_bus,
   shb_rsp_if.source  rsp_bus,
   shb_csr_if.sink    csr_bus
);

   shb_pkg::cmd_type     cmd;
   shb_pkg::status_type  status;

   assign csr_bus.ready = 1'b1;

   shb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   shb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_data_byte      (req_bus.data_byte),
      .req_first_byte     (req_bus.first_byte),
      .req_last_byte      (req_bus.last_byte),
      .req_is_empty       (req_bus.is_empty),
      .req_key_length     (req_bus.key_length),
      .req_hash_index     (req_bus.hash_index),
      .csr_write          (csr_bus.valid),
      .csr_instance_count (csr_bus.instance_count),
      .rsp_hash_value     (rsp_bus.hash_value),
      .rsp_index_error    (rsp_bus.index_error),
      .rsp_partition      (rsp_bus.partition)
   );

endmodule
`default_nettype wire

[design/shb_checker.sv]
// port-level checks of the string hash bank and their bind
`default_nettype none
module shb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           req_last_byte,
   input wire logic                           req_is_empty,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [shb_pkg::HASH_W-1:0]     rsp_hash_value,
   input wire logic                           rsp_index_error
);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result changed while stalled");

   // an item that ends a key stops intake for the remainder steps
   a_term_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_last_byte || req_is_empty) |=> !req_ready ##1 !req_ready)
      else $error("intake not stalled after key end");

   // a new result only appears while intake is held off
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a key end");

   // a bad index reports a zero hash
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_hash_value == '0)
      else $error("index error with nonzero hash");

endmodule

bind string_hash_bank shb_checker u_shb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_last_byte   (req_bus.last_byte),
   .req_is_empty    (req_bus.is_empty),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_hash_value  (rsp_bus.hash_value),
   .rsp_index_error (rsp_bus.index_error)
);
`default_nettype wire

[tb/tb_top.sv]
// testbench of string_hash_bank: directed and random keys checked against a local hash predictor
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [shb_pkg::INDEX_W-1:0] IDX_FIRST_BAD = shb_pkg::IDX_AP + 4'd1;
   localparam logic [shb_pkg::INDEX_W-1:0] IDX_TOP       = 4'hF;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 190;
   localparam int SETTLE       = 16;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [shb_pkg::BYTE_W-1:0]  data_byte;
      logic                        first_byte;
      logic                        last_byte;
      logic                        is_empty;
      logic [shb_pkg::HASH_W-1:0]  key_length;
      logic [shb_pkg::INDEX_W-1:0] hash_index;
   } key_item_type;

   typedef struct packed {
      logic [shb_pkg::HASH_W-1:0] hash_value;
      logic                       index_error;
      logic [shb_pkg::PART_W-1:0] partition;
   } hash_result_type;

   typedef struct packed {
      key_item_type    item;
      logic            known;
      hash_result_type result;
   } dir_row_type;

   typedef struct packed {
      logic [31:0] rs, rs_mult, js, pjw, elf, bkdr, sdbm, djb, dek, bp, fnv, ap;
      logic        odd_byte;
   } hash_bank_type;

   logic clock = 1'b0;
   logic reset;

   shb_req_if req_bus ();
   shb_rsp_if rsp_bus ();
   shb_csr_if csr_bus ();

   string_hash_bank u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   hash_bank_type                  bank;
   logic [shb_pkg::INDEX_W-1:0]    chosen_index;
   logic [shb_pkg::COUNT_W-1:0]    partition_count;
   hash_result_type                pending_results [$];
   int                             errors = 0;
   int                             items_sent = 0;
   int                             results_seen = 0;
   bit                             steady_flow = 1'b0;
   dir_row_type                    directed_rows [25];
   logic [shb_pkg::COUNT_W-1:0]    phase_counts [PHASES];

   function automatic hash_bank_type restart_bank(logic [31:0] len);
      hash_bank_type s;
      s = '0;
      s.rs_mult = 32'd63689;
      s.js      = 32'd1315423911;
      s.djb     = 32'd5381;
      s.dek     = len;
      s.bp      = len;
      s.ap      = 32'hAAAAAAAA;
      return s;
   endfunction

   function automatic hash_bank_type fold_byte(hash_bank_type s, logic [7:0] b);
      logic [31:0] c, h, t;
      c = {{24{b[7]}}, b};
      s.rs = s.rs * s.rs_mult + c;
      s.rs_mult = s.rs_mult * 32'd378551;
      s.js = s.js ^ ((s.js << 5) + c + (s.js >> 2));
      h = (s.pjw << 4) + c;
      t = h & 32'hF0000000;
      if (t != 0) h = (h ^ (t >> 24)) & 32'h0FFFFFFF;
      s.pjw = h;
      h = (s.elf << 4) + c;
      t = h & 32'hF0000000;
      if (t != 0) h = h ^ (t >> 24);
      s.elf = h & ~t;
      s.bkdr = s.bkdr * 32'd131 + c;
      s.sdbm = c + (s.sdbm << 6) + (s.sdbm << 16) - s.sdbm;
      s.djb = (s.djb << 5) + s.djb + c;
      s.dek = ((s.dek << 5) ^ (s.dek >> 27)) ^ c;
      s.bp = (s.bp << 7) ^ c;
      s.fnv = (s.fnv * 32'h811C9DC5) ^ c;
      // ap alternates its fold by byte position
      if (!s.odd_byte) s.ap = s.ap ^ ((s.ap << 7) ^ (c * (s.ap >> 3)));
      else s.ap = s.ap ^ ~((s.ap << 11) + (c ^ (s.ap >> 5)));
      s.odd_byte = ~s.odd_byte;
      return s;
   endfunction

   function automatic logic [31:0] pick_hash(hash_bank_type s,
                                             logic [shb_pkg::INDEX_W-1:0] idx);
      unique case (idx)
         shb_pkg::IDX_RS:   return s.rs;
         shb_pkg::IDX_JS:   return s.js;
         shb_pkg::IDX_PJW:  return s.pjw;
         shb_pkg::IDX_ELF:  return s.elf;
         shb_pkg::IDX_BKDR: return s.bkdr;
         shb_pkg::IDX_SDBM: return s.sdbm;
         shb_pkg::IDX_DJB:  return s.djb;
         shb_pkg::IDX_DEK:  return s.dek;
         shb_pkg::IDX_BP:   return s.bp;
         shb_pkg::IDX_FNV:  return s.fnv;
         shb_pkg::IDX_AP:   return s.ap;
         default:           return 32'd0;
      endcase
   endfunction

   task automatic predict_item(input key_item_type it, output bit emits,
                               output hash_result_type r);
      logic [31:0] divisor;
      emits = 1'b0;
      r = '0;
      if (it.is_empty || it.first_byte) begin
         bank = restart_bank(it.key_length);
         chosen_index = it.hash_index;
      end
      if (!it.is_empty) begin
         bank = fold_byte(bank, it.data_byte);
         if (!it.last_byte) return;
      end
      divisor = (partition_count == 0) ? 32'd1 :
                (partition_count > shb_pkg::COUNT_MAX) ? 32'd1024 : 32'(partition_count);
      r.hash_value = pick_hash(bank, chosen_index);
      r.index_error = chosen_index > shb_pkg::IDX_AP;
      r.partition = shb_pkg::PART_W'(bank.bkdr % divisor);
      emits = 1'b1;
   endtask

   task automatic send_key_item(input key_item_type it, input bit known,
                                input hash_result_type typed);
      bit emits;
      hash_result_type r;
      if (!steady_flow && $urandom_range(0, 99) < 7) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= it.data_byte;
      req_bus.first_byte <= it.first_byte;
      req_bus.last_byte  <= it.last_byte;
      req_bus.is_empty   <= it.is_empty;
      req_bus.key_length <= it.key_length;
      req_bus.hash_index <= it.hash_index;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_item(it, emits, r);
      if (emits) pending_results.push_back(known ? typed : r);
      items_sent++;
   endtask

   // complete = 0 gives a key abandoned before its last byte
   task automatic send_random_key(input bit complete);
      int len, cut, sel;
      key_item_type it;
      sel = $urandom_range(0, 99);
      if (sel < 8) len = 0;
      else if (sel < 80) len = $urandom_range(1, 8);
      else if (sel < 95) len = $urandom_range(9, 24);
      else len = $urandom_range(25, 64);
      it.hash_index = ($urandom_range(0, 99) < 85) ?
                      shb_pkg::INDEX_W'($urandom_range(0, 10)) :
                      shb_pkg::IDX_AP + shb_pkg::INDEX_W'($urandom_range(1, 5));
      it.key_length = ($urandom_range(0, 3) == 0) ? $urandom : 32'(len);
      if (len == 0) begin
         // empty key: byte and framing bits are don't-care
         it.is_empty   = 1'b1;
         it.data_byte  = shb_pkg::BYTE_W'($urandom);
         it.first_byte = 1'($urandom);
         it.last_byte  = 1'($urandom);
         send_key_item(it, 1'b0, '0);
         return;
      end
      cut = complete ? len : $urandom_range(1, len);
      it.is_empty = 1'b0;
      for (int i = 0; i < cut; i++) begin
         it.data_byte  = shb_pkg::BYTE_W'($urandom);
         it.first_byte = (i == 0);
         it.last_byte  = complete && (i == len - 1);
         send_key_item(it, 1'b0, '0);
      end
   endtask

   task automatic send_stray_byte();
      key_item_type it;
      it.data_byte  = shb_pkg::BYTE_W'($urandom);
      it.first_byte = 1'b0;
      it.last_byte  = 1'($urandom);
      it.is_empty   = 1'b0;
      it.key_length = $urandom;
      it.hash_index = shb_pkg::INDEX_W'($urandom);
      send_key_item(it, 1'b0, '0);
   endtask

   task automatic run_phase(input int n);
      int stop, sel;
      stop = items_sent + n;
      while (items_sent < stop) begin
         sel = $urandom_range(0, 99);
         if (sel < 80) send_random_key(1'b1);
         else if (sel < 90) send_random_key(1'b0);
         else send_stray_byte();
      end
      // close the key before the register may change
      send_random_key(1'b1);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_instance_count(input logic [shb_pkg::COUNT_W-1:0] v);
      csr_bus.valid          <= 1'b1;
      csr_bus.instance_count <= v;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      partition_count = v;
   endtask

   task automatic check_result();
      hash_result_type exp_r;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result, expected none, got %h/%b/%h", $time,
                  rsp_bus.hash_value, rsp_bus.index_error, rsp_bus.partition);
         errors++;
      end else begin
         exp_r = pending_results.pop_front();
         if (rsp_bus.hash_value !== exp_r.hash_value) begin
            $display("%0t: hash_value mismatch, expected %h, got %h", $time,
                     exp_r.hash_value, rsp_bus.hash_value);
            errors++;
         end
         if (rsp_bus.index_error !== exp_r.index_error) begin
            $display("%0t: index_error mismatch, expected %b, got %b", $time,
                     exp_r.index_error, rsp_bus.index_error);
            errors++;
         end
         if (rsp_bus.partition !== exp_r.partition) begin
            $display("%0t: partition mismatch, expected %0d, got %0d", $time,
                     exp_r.partition, rsp_bus.partition);
            errors++;
         end
      end
      results_seen++;
   endtask

   initial begin : result_sink
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            check_result();
            // one long hold-off so the result register backs up into req
            if (results_seen == 60 && !hold_done) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 7);
         end
      end
   end

   initial begin : stimulus
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.data_byte      <= '0;
      req_bus.first_byte     <= 1'b0;
      req_bus.last_byte      <= 1'b0;
      req_bus.is_empty       <= 1'b0;
      req_bus.key_length     <= '0;
      req_bus.hash_index     <= shb_pkg::IDX_RS;
      csr_bus.valid          <= 1'b0;
      csr_bus.instance_count <= shb_pkg::COUNT_RESET;
      bank = restart_bank(32'd0);
      chosen_index = shb_pkg::IDX_RS;
      partition_count = shb_pkg::COUNT_RESET;

      directed_rows = '{
         // stray byte straight after reset folds into the reset state
         '{'{8'h41, 1'b0, 1'b1, 1'b0, 32'd0, shb_pkg::IDX_RS},
           1'b1, '{32'h41, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_RS},
           1'b1, '{32'd0, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_JS},
           1'b1, '{32'd1315423911, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_PJW},
           1'b1, '{32'd0, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_ELF},
           1'b1, '{32'd0, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_BKDR},
           1'b1, '{32'd0, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_SDBM},
           1'b1, '{32'd0, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_DJB},
           1'b1, '{32'd5381, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'hFFFFFFFF, shb_pkg::IDX_DEK},
           1'b1, '{32'hFFFFFFFF, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'h5A5A1234, shb_pkg::IDX_BP},
           1'b1, '{32'h5A5A1234, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_FNV},
           1'b1, '{32'd0, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, shb_pkg::IDX_AP},
           1'b1, '{32'hAAAAAAAA, 1'b0, 10'd0}},
         '{'{8'h00, 1'b0, 1'b0, 1'b1, 32'd0, IDX_FIRST_BAD},
           1'b1, '{32'd0, 1'b1, 10'd0}},
         // empty key ignores its byte and framing bits
         '{'{8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFFFFFF, IDX_TOP},
           1'b1, '{32'd0, 1'b1, 10'd0}},
         '{'{8'h7F, 1'b1, 1'b1, 1'b0, 32'd1, shb_pkg::IDX_BKDR},
           1'b1, '{32'h7F, 1'b0, 10'd0}},
         '{'{8'h80, 1'b1, 1'b1, 1'b0, 32'd1, shb_pkg::IDX_BKDR},
           1'b1, '{32'hFFFFFF80, 1'b0, 10'd0}},
         '{'{8'hFF, 1'b1, 1'b1, 1'b0, 32'd1, shb_pkg::IDX_FNV},
           1'b1, '{32'hFFFFFFFF, 1'b0, 10'd0}},
         '{'{8'h00, 1'b1, 1'b1, 1'b0, 32'd1, shb_pkg::IDX_DJB},
           1'b1, '{32'd177573, 1'b0, 10'd0}},
         '{'{8'h61, 1'b1, 1'b0, 1'b0, 32'd3, shb_pkg::IDX_AP}, 1'b0, '0},
         '{'{8'h62, 1'b0, 1'b0, 1'b0, 32'd3, shb_pkg::IDX_AP}, 1'b0, '0},
         '{'{8'h63, 1'b0, 1'b1, 1'b0, 32'd3, shb_pkg::IDX_AP}, 1'b0, '0},
         '{'{8'hFF, 1'b1, 1'b0, 1'b0, 32'hFFFFFFFF, shb_pkg::IDX_RS}, 1'b0, '0},
         // a second first byte restarts the key
         '{'{8'h80, 1'b1, 1'b0, 1'b0, 32'd2, shb_pkg::IDX_ELF}, 1'b0, '0},
         '{'{8'h00, 1'b0, 1'b1, 1'b0, 32'd2, shb_pkg::IDX_ELF}, 1'b0, '0},
         // byte after a finished key keeps folding, index kept
         '{'{8'hC3, 1'b0, 1'b1, 1'b0, 32'd0, shb_pkg::IDX_SDBM}, 1'b0, '0}
      };
      phase_counts = '{11'd0, 11'd1024, 11'd2047, 11'd1025, 11'd1, 11'd1023, 11'd2,
                       11'd0, 11'd0};
      phase_counts[7] = shb_pkg::COUNT_W'($urandom_range(3, 2047));
      phase_counts[8] = shb_pkg::COUNT_W'($urandom_range(3, 2047));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_key_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].result);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         steady_flow = (p == 3 || p == 4);
         write_instance_count(phase_counts[p]);
         run_phase(PHASE_ITEMS);
         wait_idle();
      end

      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
design/shb_pkg.sv
design/shb_if.sv
design/shb_ctrl.sv
design/shb_datapath.sv
design/string_hash_bank.sv
design/shb_checker.sv
tb/tb_top.sv
